// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: always");

// When ante holds, cons must hold on the next clock.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`endif

// ===== design/altrm_pkg.sv =====
// Types and constants for the AXI4-Lite trace replay master.
`timescale 1ns / 1ps
`default_nettype none

package altrm_pkg;

   // Queue depth must be a power of two so the pointers wrap at twice the depth.
   localparam int QUEUE_DEPTH = 256;
   localparam int IDX_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int PTR_WIDTH   = IDX_WIDTH + 1;

   localparam logic [15:0] IDLE_WAIT_RESET = 16'd100;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_AR   = 3'd1,
      PH_R    = 3'd2,
      PH_AW   = 3'd3,
      PH_W    = 3'd4,
      PH_B    = 3'd5
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic        entry_is_read;
      logic [31:0] entry_address;
      logic [31:0] entry_payload;
      logic        slave_awready;
      logic        slave_wready;
      logic        slave_bvalid;
      logic        slave_arready;
      logic        slave_rvalid;
      logic [31:0] slave_rdata;
   } req_type;

   typedef struct packed {
      logic        aw_valid;
      logic        w_valid;
      logic        b_ready;
      logic        ar_valid;
      logic        r_ready;
      logic [31:0] bus_address;
      logic [31:0] bus_wdata;
      logic        replay_done;
      logic        load_dropped;
   } rsp_type;

   typedef struct packed {
      logic        is_read;
      logic [31:0] address;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== design/axi_lite_trace_replay_master.sv =====
// Top level of the AXI4-Lite trace replay master.
// Usage:
//   req channel: one beat is either a load (kind 0) pushing a write or
//   read-until-match entry into a 256-entry queue, or a tick (kind 1)
//   carrying one bus cycle of slave handshakes and read data.
//   rsp channel: exactly one beat per req beat, giving the master's bus
//   outputs for the following bus cycle, the sticky done flag and a
//   drop flag for a load that met a full queue.
//   csr port: csr_write_enable/csr_write_data set the 16-bit idle wait
//   (ticks spent idle before the head entry starts); write only while idle.
// Timing: a req beat is taken every cycle while req_stall is low; its rsp
//   beat is valid on the next cycle (one beat per cycle throughput), set
//   by the single state update between the input and the output register.
//   The head entry is read from the queue memory into a register ahead of use.
// Stall: while rsp_valid is high and rsp_stall is high the output register
//   holds and req_stall is raised; nothing is lost.
// Reset: synchronous; empties the queue, returns to idle with a zero idle
//   count, clears the done flag and loads idle wait with 100.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module axi_lite_trace_replay_master (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire altrm_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output altrm_pkg::rsp_type     rsp_payload,
   input  wire                    csr_write_enable,
   input  wire  [15:0]            csr_write_data
);

   altrm_pkg::phase_type         phase_ff, phase_in;
   logic [15:0]                  idle_count_ff, idle_count_in;
   logic [15:0]                  tick_count;
   logic [15:0]                  idle_wait_ff;
   logic                         done_ff, done_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   altrm_pkg::rsp_type           rsp_ff, rsp_in;
   logic                         accept;
   logic                         push, pop, dropped;
   altrm_pkg::entry_type         push_entry;
   altrm_pkg::entry_type         head_entry;
   altrm_pkg::queue_status_type  q_status;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign tick_count  = idle_count_ff + 16'd1;

   assign push_entry.is_read = req_payload.entry_is_read;
   assign push_entry.address = req_payload.entry_address;
   assign push_entry.payload = req_payload.entry_payload;

   altrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // next state
   always_comb begin
      phase_in      = phase_ff;
      idle_count_in = idle_count_ff;
      done_in       = done_ff;
      push          = 1'b0;
      pop           = 1'b0;
      dropped       = 1'b0;
      if (accept) begin
         if (req_payload.kind == altrm_pkg::KIND_LOAD) begin
            if (q_status.full) begin
               dropped = 1'b1;
            end else begin
               push = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               altrm_pkg::PH_IDLE: begin
                  idle_count_in = tick_count;
                  if (tick_count == idle_wait_ff) begin
                     if (q_status.empty) begin
                        done_in       = 1'b1;
                        idle_count_in = '0;
                     end else if (head_entry.is_read) begin
                        phase_in = altrm_pkg::PH_AR;
                     end else begin
                        phase_in = altrm_pkg::PH_AW;
                     end
                  end
               end
               altrm_pkg::PH_AR: begin
                  if (req_payload.slave_arready) begin
                     phase_in = altrm_pkg::PH_R;
                  end
               end
               altrm_pkg::PH_R: begin
                  if (req_payload.slave_rvalid) begin
                     phase_in      = altrm_pkg::PH_IDLE;
                     idle_count_in = '0;
                     pop           = (head_entry.payload == req_payload.slave_rdata);
                  end
               end
               altrm_pkg::PH_AW: begin
                  if (req_payload.slave_awready) begin
                     phase_in = altrm_pkg::PH_W;
                  end
               end
               altrm_pkg::PH_W: begin
                  if (req_payload.slave_wready) begin
                     phase_in = altrm_pkg::PH_B;
                  end
               end
               altrm_pkg::PH_B: begin
                  if (req_payload.slave_bvalid) begin
                     phase_in      = altrm_pkg::PH_IDLE;
                     idle_count_in = '0;
                     pop           = 1'b1;
                  end
               end
               default: begin
                  phase_in      = altrm_pkg::PH_IDLE;
                  idle_count_in = '0;
               end
            endcase
         end
      end
   end

   // outputs for the bus cycle after this beat; a pop always lands in idle,
   // so the registered head entry is current wherever it is shown
   always_comb begin
      rsp_in.aw_valid     = (phase_in == altrm_pkg::PH_AW);
      rsp_in.w_valid      = (phase_in == altrm_pkg::PH_W);
      rsp_in.b_ready      = (phase_in == altrm_pkg::PH_B);
      rsp_in.ar_valid     = (phase_in == altrm_pkg::PH_AR);
      rsp_in.r_ready      = (phase_in == altrm_pkg::PH_R);
      rsp_in.bus_address  = (phase_in == altrm_pkg::PH_AW || phase_in == altrm_pkg::PH_AR)
                          ? head_entry.address : '0;
      rsp_in.bus_wdata    = (phase_in == altrm_pkg::PH_W) ? head_entry.payload : '0;
      rsp_in.replay_done  = done_in;
      rsp_in.load_dropped = dropped;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= altrm_pkg::PH_IDLE;
         idle_count_ff <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idle_wait_ff  <= altrm_pkg::IDLE_WAIT_RESET;
      end else begin
         phase_ff      <= phase_in;
         idle_count_ff <= idle_count_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            idle_wait_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_NEXT(a_done_sticky, clock, reset, done_ff, done_ff)
   `ASSERT_ALWAYS(a_drop_on_load, clock, reset, !dropped || (accept && q_status.full))
   `ASSERT_NEXT(a_idle_after_pop, clock, reset, pop, phase_ff == altrm_pkg::PH_IDLE)

endmodule

`default_nettype wire

// ===== design/altrm_queue.sv =====
// Entry queue: one memory, head/tail pointers, registered head read with write bypass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module altrm_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire altrm_pkg::entry_type    push_entry,
   input  wire                          pop,
   output altrm_pkg::entry_type         head_entry,
   output altrm_pkg::queue_status_type  status
);

   altrm_pkg::entry_type                  mem [altrm_pkg::QUEUE_DEPTH];
   altrm_pkg::entry_type                  head_entry_ff;
   logic [altrm_pkg::PTR_WIDTH-1:0]       head_ff, head_in;
   logic [altrm_pkg::PTR_WIDTH-1:0]       tail_ff, tail_in;
   logic [altrm_pkg::IDX_WIDTH-1:0]       head_slot_in;
   logic [altrm_pkg::IDX_WIDTH-1:0]       tail_slot;

   assign head_in      = pop  ? head_ff + 1'b1 : head_ff;
   assign tail_in      = push ? tail_ff + 1'b1 : tail_ff;
   assign head_slot_in = head_in[altrm_pkg::IDX_WIDTH-1:0];
   assign tail_slot    = tail_ff[altrm_pkg::IDX_WIDTH-1:0];

   assign status.empty = (head_ff == tail_ff);
   assign status.full  = (head_ff[altrm_pkg::IDX_WIDTH] != tail_ff[altrm_pkg::IDX_WIDTH])
                      && (head_ff[altrm_pkg::IDX_WIDTH-1:0] == tail_slot);
   assign head_entry   = head_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_slot] <= push_entry;
      end
   end

   // push into an empty queue lands on the head slot: forward it
   always_ff @(posedge clock) begin
      if (push && (tail_slot == head_slot_in)) begin
         head_entry_ff <= push_entry;
      end else begin
         head_entry_ff <= mem[head_slot_in];
      end
   end

   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(pop && status.empty))
   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && status.full))
   `ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !status.empty)

endmodule

`default_nettype wire
